// ===== design/r2a_pkg.sv =====
package r2a_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int VALUE_W        = 32;
   localparam int RADIX_W        = 8;
   localparam int DIGIT_W        = 6;
   localparam int CHAR_W         = 7;

   localparam logic [DIGIT_W-1:0] DEFAULT_RADIX  = 6'd10;
   localparam logic [DIGIT_W-1:0] MAX_RADIX      = 6'd36;
   localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;
   localparam logic [CHAR_W-1:0]  ASCII_ZERO     = 7'd48;
   localparam logic [CHAR_W-1:0]  ASCII_UPPER_A  = 7'd65;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic quot_zero;
      logic emit_last;
   } status_type;

   function automatic logic [DIGIT_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
      logic [DIGIT_W-1:0] res;
      if (r < 8'd2) begin
         res = DEFAULT_RADIX;
      end else if (r > 8'(MAX_RADIX)) begin
         res = MAX_RADIX;
      end else begin
         res = r[DIGIT_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] res;
      if (d < DECIMAL_DIGITS) begin
         res = ASCII_ZERO + CHAR_W'(d);
      end else begin
         res = ASCII_UPPER_A + CHAR_W'(d - DECIMAL_DIGITS);
      end
      return res;
   endfunction

endpackage

// ===== design/radix_to_ascii_digits_top.sv =====
// Converts an unsigned value to ASCII digits in the given radix (below 2 means
// 10, above 36 clamps to 36), most significant character first, the last one
// flagged by rsp_last_char; zero gives a single '0'. An item is taken when
// start is high and busy is low. Each digit is worked out by a shared bit-serial
// divider, after which the characters are read back from the digit store one
// per cycle. Each character appears on the rsp_ ports for one cycle with
// rsp_valid high, in the cycle after its store read; the receiver cannot stall,
// so capture every strobe. The next item may be started while the final
// character is shown.
module radix_to_ascii_digits_top #(
   parameter int VALUE_BITS = r2a_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [r2a_pkg::VALUE_W-1:0]   req_value,
   input  logic [r2a_pkg::RADIX_W-1:0]   req_radix,
   output logic                          rsp_valid,
   output logic [r2a_pkg::CHAR_W-1:0]    rsp_char_code,
   output logic                          rsp_last_char
);
   import r2a_pkg::*;

   cmd_type    cmd;
   status_type status;

   r2a_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   r2a_dpath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_value     (req_value),
      .req_radix     (req_radix),
      .rsp_valid     (rsp_valid),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

endmodule

// ===== design/r2a_ctrl.sv =====
module r2a_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  r2a_pkg::status_type status,
   output r2a_pkg::cmd_type    cmd
);
   import r2a_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            // finish a digit; leave once the quotient runs out
            if (status.div_last && status.quot_zero) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== design/r2a_dpath.sv =====
module r2a_dpath #(
   parameter int VALUE_BITS = r2a_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  r2a_pkg::cmd_type              cmd,
   output r2a_pkg::status_type           status,
   input  logic [r2a_pkg::VALUE_W-1:0]   req_value,
   input  logic [r2a_pkg::RADIX_W-1:0]   req_radix,
   output logic                          rsp_valid,
   output logic [r2a_pkg::CHAR_W-1:0]    rsp_char_code,
   output logic                          rsp_last_char
);
   import r2a_pkg::*;

   localparam int IW = $clog2(VALUE_BITS);
   localparam int CW = $clog2(VALUE_BITS + 1);
   localparam int LW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [DIGIT_W-1:0]    radix_ff;
   logic [IW-1:0]         bit_ff;
   logic [CW-1:0]         count_ff;
   logic [DIGIT_W-1:0]    digit_store [VALUE_BITS];
   logic [DIGIT_W-1:0]    rd_data_ff;
   logic                  rsp_valid_ff;
   logic                  last_ff;

   logic [DIGIT_W:0]      trial;
   logic                  ge;
   logic [IW-1:0]         rd_addr;

   // one restoring division step: shift in the dividend MSB, subtract if it fits
   always_comb begin
      trial   = {rem_ff, quot_ff[VALUE_BITS-1]};
      ge      = (trial >= {1'b0, radix_ff});
      rem_in  = ge ? DIGIT_W'(trial - {1'b0, radix_ff}) : trial[DIGIT_W-1:0];
      quot_in = {quot_ff[VALUE_BITS-2:0], ge};
   end

   assign rd_addr = IW'(count_ff - 1'b1);

   assign status.div_last  = (bit_ff == IW'(VALUE_BITS - 1));
   assign status.quot_zero = (quot_in == '0);
   assign status.emit_last = (count_ff == CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff  <= '0;
         rem_ff   <= '0;
         radix_ff <= DEFAULT_RADIX;
         bit_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.load) begin
         quot_ff  <= VALUE_BITS'(req_value[LW-1:0]);
         rem_ff   <= '0;
         radix_ff <= eff_radix(req_radix);
         bit_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.step) begin
         quot_ff <= quot_in;
         if (status.div_last) begin
            // digit done: store it and restart on the quotient
            rem_ff   <= '0;
            bit_ff   <= '0;
            count_ff <= count_ff + 1'b1;
         end else begin
            rem_ff <= rem_in;
            bit_ff <= bit_ff + 1'b1;
         end
      end else if (cmd.emit) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && status.div_last) begin
         digit_store[count_ff[IW-1:0]] <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rd_data_ff <= digit_store[rd_addr];
         last_ff    <= status.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = digit_to_ascii(rd_data_ff);
   assign rsp_last_char = last_ff;

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      rem_ff < radix_ff)
      else $error("remainder reached the radix");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(VALUE_BITS))
      else $error("digit count overflow");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (count_ff != '0))
      else $error("emit with no digits left");

   a_last_ends_emit: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.emit_last) |=> !cmd.emit)
      else $error("emission ran past the last digit");

endmodule
